/* rtl/plint_pkg.sv */
// Shared types and constants for the piecewise linear interpolator.
`timescale 1ns / 1ps
`default_nettype none
package plint_pkg;
  localparam int MAX_KNOTS = 256;
  localparam int ADDR_W    = $clog2(MAX_KNOTS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int VAL_W     = 32;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BELOW = 3'd1;
  localparam logic [2:0] ST_ABOVE = 3'd2;
  localparam logic [2:0] ST_FEW   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_ORDER = 3'd5;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/plint_in_if.sv */
// Input channel: function code and knot or query operands.
`timescale 1ns / 1ps
`default_nettype none
interface plint_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  modport source(output valid, func, x_value, y_value, input ready);
  modport sink(input valid, func, x_value, y_value, output ready);
endinterface
`default_nettype wire

/* rtl/plint_out_if.sv */
// Output channel: interpolated ordinate and status.
`timescale 1ns / 1ps
`default_nettype none
interface plint_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] y_result;
  logic [2:0]        status;
  modport source(output valid, y_result, status, input ready);
  modport sink(input valid, y_result, status, output ready);
endinterface
`default_nettype wire

/* rtl/piecewise_linear_interpolator.sv */
// Top level of the piecewise linear interpolator.
// Usage:
//   req carries one item per valid/ready handshake: func (clear, append knot,
//   query, or no-op), x_value and y_value in signed Q16.16.
//   rsp returns exactly one item per request: y_result and status.
//   Knots are kept in two 256-entry RAMs (abscissas, ordinates); the first
//   and last abscissa and last ordinate also sit in registers for range checks.
// Processing:
//   Clear, append, no-op, every flagged query and a query at the last
//   abscissa are answered directly by the back end, with no search.
//   Any other query walks the segments forward, each search step a RAM
//   read plus a compare, and then runs a two-step 33x16 multiply and a
//   33-step restoring divide. Every item passes the input queue first.
//   Only one item is worked on at a time in the back end.
// Stall behavior:
//   A two-entry queue accepts until full while the back end works; the result
//   register holds its item until rsp.ready, and the back end takes no new
//   item until it is drained.
// Reset:
//   Synchronous rst empties the table, sets the segment pointer to one and
//   drops all valids. RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_interpolator (
  input  wire logic   clk,
  input  wire logic   rst,
  plint_in_if.sink    req,
  plint_out_if.source rsp
);
  logic            cmd_valid;
  logic            cmd_ready;
  plint_pkg::cmd_t cmd;

  plint_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  plint_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp(rsp)
  );
endmodule
`default_nettype wire

/* rtl/plint_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module plint_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/plint_front.sv */
// Front end: accepts items, decodes the function code, two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module plint_front (
  input  wire logic          clk,
  input  wire logic          rst,
  plint_in_if.sink           req,
  output      logic          cmd_valid,
  input  wire logic          cmd_ready,
  output      plint_pkg::cmd_t cmd
);
  plint_pkg::cmd_t q_data [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  plint_pkg::cmd_t dec;
  logic            push;
  logic            pop;

  always_comb begin
    dec.x = req.x_value;
    dec.y = req.y_value;
    case (req.func)
      plint_pkg::FUNC_CLEAR:  dec.op = plint_pkg::OP_CLEAR;
      plint_pkg::FUNC_APPEND: dec.op = plint_pkg::OP_APPEND;
      plint_pkg::FUNC_QUERY:  dec.op = plint_pkg::OP_QUERY;
      default:                dec.op = plint_pkg::OP_NOP;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* rtl/plint_back.sv */
// Back end: knot table, segment search, multiply, serial divide, result register.
`timescale 1ns / 1ps
`default_nettype none
module plint_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output      logic            cmd_ready,
  input  wire plint_pkg::cmd_t cmd,
  plint_out_if.source          rsp
);
  localparam int AW = plint_pkg::ADDR_W;
  localparam int CW = plint_pkg::CNT_W;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_LO      = 12'b000000000010,
    S_LOCHK   = 12'b000000000100,
    S_SCAN    = 12'b000000001000,
    S_SCANCHK = 12'b000000010000,
    S_RD0     = 12'b000000100000,
    S_RD1     = 12'b000001000000,
    S_DIFF    = 12'b000010000000,
    S_MUL0    = 12'b000100000000,
    S_MUL1    = 12'b001000000000,
    S_DIV     = 12'b010000000000,
    S_FIN     = 12'b100000000000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [AW-1:0]      seg_ptr;
  logic [AW-1:0]      k;
  logic signed [31:0] first_x, last_x, last_y;
  logic signed [31:0] xq, x0, y0;
  logic [32:0]        mag, dx;
  logic [31:0]        t;
  logic               neg;
  logic [63:0]        prod;
  logic [33:0]        rem;
  logic [32:0]        dlo;
  logic [32:0]        quo;
  logic [5:0]         step;

  logic signed [31:0] rd_x, rd_y;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [CW-1:0]      last;
  logic               take;
  logic               full;
  logic [33:0]        sh;
  logic [33:0]        sh_sub;
  logic signed [34:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] imm_y;
  logic [2:0]         imm_status;
  logic               go_search;

  plint_ram #(.WIDTH(32), .DEPTH(plint_pkg::MAX_KNOTS)) u_xram (
    .clk(clk), .we(we), .waddr(count[AW-1:0]), .wdata(cmd.x),
    .raddr(raddr), .rdata(rd_x)
  );
  plint_ram #(.WIDTH(32), .DEPTH(plint_pkg::MAX_KNOTS)) u_yram (
    .clk(clk), .we(we), .waddr(count[AW-1:0]), .wdata(cmd.y),
    .raddr(raddr), .rdata(rd_y)
  );

  assign last      = count - CW'(1);
  assign full      = (count >= CW'(plint_pkg::MAX_KNOTS));
  assign cmd_ready = (state == S_IDLE) && !rsp.valid;
  assign take      = cmd_valid && cmd_ready;

  // immediate answer for everything that needs no search
  always_comb begin
    imm_y      = '0;
    imm_status = plint_pkg::ST_OK;
    go_search  = 1'b0;
    case (cmd.op)
      plint_pkg::OP_APPEND: begin
        if (full) begin
          imm_status = plint_pkg::ST_FULL;
        end else if ((count != '0) && (cmd.x <= last_x)) begin
          imm_status = plint_pkg::ST_ORDER;
        end
      end
      plint_pkg::OP_QUERY: begin
        if (count < CW'(2)) begin
          imm_status = plint_pkg::ST_FEW;
        end else if (cmd.x < first_x) begin
          imm_status = plint_pkg::ST_BELOW;
        end else if (cmd.x > last_x) begin
          imm_status = plint_pkg::ST_ABOVE;
        end else if (cmd.x == last_x) begin
          imm_y = last_y;
        end else begin
          go_search = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign we = take && (cmd.op == plint_pkg::OP_APPEND) && (imm_status == plint_pkg::ST_OK);

  always_comb begin
    case (state)
      S_LO, S_RD0: raddr = k - AW'(1);
      default:     raddr = k;
    endcase
  end

  assign sh     = {rem[32:0], dlo[32]};
  assign sh_sub = sh - {1'b0, dx};
  assign sum    = neg ? (35'(y0) - 35'(quo)) : (35'(y0) + 35'(quo));
  always_comb begin
    if (sum > 35'sd2147483647)       sat = 32'sh7fffffff;
    else if (sum < -35'sd2147483648) sat = 32'sh80000000;
    else                             sat = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      seg_ptr   <= AW'(1);
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            rsp.y_result <= imm_y;
            rsp.status   <= imm_status;
            rsp.valid    <= !go_search;
            case (cmd.op)
              plint_pkg::OP_CLEAR: begin
                count   <= '0;
                seg_ptr <= AW'(1);
              end
              plint_pkg::OP_APPEND: begin
                if (we) begin
                  if (count == '0) first_x <= cmd.x;
                  last_x <= cmd.x;
                  last_y <= cmd.y;
                  count  <= count + CW'(1);
                end
              end
              plint_pkg::OP_QUERY: begin
                if (go_search) begin
                  xq <= cmd.x;
                  if ((seg_ptr != '0) && ({1'b0, seg_ptr} <= last)) begin
                    k     <= seg_ptr;
                    state <= S_LO;
                  end else begin
                    k     <= AW'(1);
                    state <= S_SCAN;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_LO:    state <= S_LOCHK;
        S_LOCHK: begin
          if (xq < rd_x) k <= AW'(1);
          state <= S_SCAN;
        end
        S_SCAN:  state <= S_SCANCHK;
        S_SCANCHK: begin
          if (({1'b0, k} < last) && (rd_x <= xq)) begin
            k     <= k + AW'(1);
            state <= S_SCAN;
          end else begin
            seg_ptr <= k;
            state   <= S_RD0;
          end
        end
        S_RD0:   state <= S_RD1;
        S_RD1: begin
          x0    <= rd_x;
          y0    <= rd_y;
          state <= S_DIFF;
        end
        S_DIFF: begin
          dx  <= 33'(rd_x) - 33'(x0);
          t   <= 32'(33'(xq) - 33'(x0));
          neg <= (rd_y < y0);
          mag <= (rd_y < y0) ? (33'(y0) - 33'(rd_y)) : (33'(rd_y) - 33'(y0));
          state <= S_MUL0;
        end
        S_MUL0: begin
          prod  <= 64'(mag * t[15:0]);
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod  <= prod + (64'(mag * t[31:16]) << 16);
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          if (step == '0) begin
            rem  <= {3'b000, prod[63:33]};
            dlo  <= prod[32:0];
            step <= 6'd1;
          end else begin
            if (sh >= {1'b0, dx}) begin
              rem <= sh_sub;
              quo <= {quo[31:0], 1'b1};
            end else begin
              rem <= sh;
              quo <= {quo[31:0], 1'b0};
            end
            dlo  <= {dlo[31:0], 1'b0};
            step <= step + 6'd1;
            if (step == 6'd33) state <= S_FIN;
          end
        end
        S_FIN: begin
          rsp.y_result <= sat;
          rsp.status   <= plint_pkg::ST_OK;
          rsp.valid    <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* bench/plint_scoreboard.sv */
// Checker for the piecewise linear interpolator: predicts each result and compares.
`timescale 1ns / 1ps
module plint_scoreboard (
  input  logic        clk,
  input  logic        rst,
  plint_in_if.sink    req_mon,
  plint_out_if.sink   rsp_mon,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic signed [31:0] y_result;
    logic [2:0]         status;
  } answer_t;

  logic signed [31:0] knot_x [plint_pkg::MAX_KNOTS];
  logic signed [31:0] knot_y [plint_pkg::MAX_KNOTS];
  int unsigned n_knots;
  int unsigned seg_ptr;
  answer_t answers_due[$];

  assign pending = answers_due.size();

  // Segment value, truncated toward y0 and saturated to 32 bits.
  function automatic logic signed [31:0] lerp(input logic signed [31:0] x0, y0, x1, y1, xq);
    longint dy, dx, t, q, r;
    logic [127:0] prod;
    dy = longint'(y1) - longint'(y0);
    dx = longint'(x1) - longint'(x0);
    t  = longint'(xq) - longint'(x0);
    if (dx == 0) return y0;
    prod = 128'(dy < 0 ? -dy : dy) * 128'(t);
    q = longint'(prod / 128'(dx));
    r = dy < 0 ? longint'(y0) - q : longint'(y0) + q;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic answer_t apply_item(input logic [1:0] func,
                                         input logic signed [31:0] xv, yv);
    answer_t a;
    int unsigned last, k;
    a = '0;
    a.status = plint_pkg::ST_OK;
    case (func)
      plint_pkg::FUNC_CLEAR: begin
        n_knots = 0;
        seg_ptr = 1;
      end
      plint_pkg::FUNC_APPEND: begin
        if (n_knots >= plint_pkg::MAX_KNOTS) a.status = plint_pkg::ST_FULL;
        else if (n_knots > 0 && xv <= knot_x[n_knots-1]) a.status = plint_pkg::ST_ORDER;
        else begin
          knot_x[n_knots] = xv;
          knot_y[n_knots] = yv;
          n_knots++;
        end
      end
      plint_pkg::FUNC_QUERY: begin
        last = n_knots - 1;
        if (n_knots < 2) a.status = plint_pkg::ST_FEW;
        else if (xv < knot_x[0]) a.status = plint_pkg::ST_BELOW;
        else if (xv > knot_x[last]) a.status = plint_pkg::ST_ABOVE;
        else if (xv == knot_x[last]) a.y_result = knot_y[last];
        else begin
          k = seg_ptr;
          // stale pointer or x behind it: restart at the first segment
          if (k < 1 || k > last || xv < knot_x[k-1]) k = 1;
          while (k < last && knot_x[k] <= xv) k++;
          seg_ptr = k;
          a.y_result = lerp(knot_x[k-1], knot_y[k-1], knot_x[k], knot_y[k], xv);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t predicted;
    int      errs;
    errs = 0;
    if (rst) begin
      n_knots    <= 0;
      seg_ptr    <= 1;
      fail_count <= 0;
      answers_due.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        predicted   = apply_item(req_mon.func, req_mon.x_value, req_mon.y_value);
        answers_due = {answers_due, predicted};
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result item: y_result %0d status %0d",
                 rsp_mon.y_result, rsp_mon.status);
          errs++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_mon.y_result !== want.y_result) begin
            $error("y_result: expected %0d, actual %0d", want.y_result, rsp_mon.y_result);
            errs++;
          end
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

/* bench/piecewise_linear_interpolator_tb.sv */
// Testbench top for the piecewise linear interpolator: stimulus and verdict.
`timescale 1ns / 1ps
module piecewise_linear_interpolator_tb;
  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   accepted;
  int   knot_total;   // knots this bench believes are stored
  logic signed [31:0] top_x;  // abscissa of the last stored knot
  logic signed [31:0] low_x;  // abscissa of the first stored knot

  plint_in_if  req ();
  plint_out_if rsp ();

  piecewise_linear_interpolator i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  plint_scoreboard i_scoreboard (
    .clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, the odd long one; some stretches with none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: ready toggles at random on its own.
  initial begin
    int hold;
    rsp.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      rsp.ready <= 1'b1;
      hold = $urandom_range(0, 99) < 30 ? 0 : $urandom_range(1, 40);
      repeat (hold) @(posedge clk);
      hold = gap_len();
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Drives one item and waits for its handshake; may leave a gap before it.
  task automatic send_item(input logic [1:0] func, input logic signed [31:0] xv, yv);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.func    <= func;
    req.x_value <= xv;
    req.y_value <= yv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    accepted++;
    // track the table the way a user would, to steer stimulus in range
    if (func == plint_pkg::FUNC_CLEAR) knot_total = 0;
    else if (func == plint_pkg::FUNC_APPEND && knot_total < plint_pkg::MAX_KNOTS &&
             (knot_total == 0 || xv > top_x)) begin
      if (knot_total == 0) low_x = xv;
      top_x = xv;
      knot_total++;
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  // Clears the table, then appends n knots, each abscissa a random step above the last (the 32-bit sum can wrap).
  task automatic build_table(input int n, input logic signed [31:0] x_start, input int step_max);
    logic signed [31:0] xv;
    xv = x_start;
    send_item(plint_pkg::FUNC_CLEAR, rand_word(), rand_word());
    for (int i = 0; i < n; i++) begin
      send_item(plint_pkg::FUNC_APPEND, xv, rand_word());
      xv = xv + $urandom_range(1, step_max);
    end
  endtask

  // Query abscissa mostly within the table, sometimes at its edges or beyond.
  function automatic logic signed [31:0] query_x();
    int r;
    longint span;
    r = $urandom_range(0, 99);
    span = longint'(top_x) - longint'(low_x);
    if (knot_total < 2 || r < 5) return rand_word();
    if (r < 10) return low_x;
    if (r < 15) return top_x;
    if (r < 18) return low_x - 1;
    if (r < 21) return top_x + 1;
    return low_x + 32'(longint'({$urandom(), $urandom()} & 64'h7fff_ffff_ffff_ffff) % (span + 1));
  endfunction

  initial begin
    int ops, r, n;
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.func    = plint_pkg::FUNC_CLEAR;
    req.x_value = '0;
    req.y_value = '0;
    accepted    = 0;
    knot_total  = 0;
    top_x       = '0;
    low_x       = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: too few knots, ordering, extremes, boundary queries, no-op.
    send_item(plint_pkg::FUNC_QUERY, 32'sd0, 32'sd0);
    send_item(plint_pkg::FUNC_APPEND, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(plint_pkg::FUNC_QUERY, 32'sh8000_0000, 32'sd0);
    send_item(plint_pkg::FUNC_APPEND, 32'sh8000_0000, 32'sd5);     // not ascending
    send_item(plint_pkg::FUNC_APPEND, 32'sd0, 32'sh8000_0000);
    send_item(plint_pkg::FUNC_APPEND, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(plint_pkg::FUNC_QUERY, 32'sh8000_0000, 32'sd0);      // first knot
    send_item(plint_pkg::FUNC_QUERY, 32'sd0, 32'sd0);              // inner knot exactly
    send_item(plint_pkg::FUNC_QUERY, 32'sh7fff_ffff, 32'sd0);      // last knot
    send_item(plint_pkg::FUNC_QUERY, 32'sh4000_0000, 32'sd0);
    send_item(plint_pkg::FUNC_QUERY, 32'shc000_0000, 32'sd0);      // pointer goes back
    send_item(plint_pkg::FUNC_APPEND, 32'sh7fff_ffff, 32'sd1);     // equal x rejected
    send_item(plint_pkg::FUNC_NOP, 32'sh7fff_ffff, 32'sh8000_0000); // unused code
    send_item(plint_pkg::FUNC_CLEAR, 32'sd0, 32'sd0);
    send_item(plint_pkg::FUNC_APPEND, 32'sd10, 32'sd0);
    send_item(plint_pkg::FUNC_APPEND, 32'sd20, 32'sd100);
    send_item(plint_pkg::FUNC_QUERY, 32'sd9, 32'sd0);              // below range
    send_item(plint_pkg::FUNC_QUERY, 32'sd21, 32'sd0);             // above range
    send_item(plint_pkg::FUNC_QUERY, 32'sd15, 32'sd0);

    // Full table: 256 knots, then a rejected append and queries near both ends.
    build_table(plint_pkg::MAX_KNOTS, -32'sd1000000, 3000);
    send_item(plint_pkg::FUNC_APPEND, 32'sh7fff_ffff, 32'sd1);
    send_item(plint_pkg::FUNC_QUERY, top_x - 1, 32'sd0);
    send_item(plint_pkg::FUNC_QUERY, low_x, 32'sd0);

    // Drain: hold off until every answer is back.
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random: mostly small tables with runs of queries, plus noise.
    ops = 0;
    while (ops < 720) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        n = $urandom_range(0, 8);
        build_table(n, rand_word() >>> $urandom_range(0, 8),
                    $urandom_range(0, 1) ? 64 : 32'h0fff_ffff);
        ops += n + 1;
      end else if (r < 80) begin
        send_item(plint_pkg::FUNC_QUERY, query_x(), rand_word());
        ops++;
      end else if (r < 92) begin
        send_item(plint_pkg::FUNC_APPEND, $urandom_range(0, 1) ? top_x + $urandom_range(1, 5000)
                                                               : rand_word(), rand_word());
        ops++;
      end else begin
        send_item(2'($urandom_range(0, 3)), rand_word(), rand_word());
        ops++;
      end
    end
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Safety net: fails the run if its thousand or so items have not finished by this time.
  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

/* sim.f */
rtl/plint_pkg.sv
rtl/plint_in_if.sv
rtl/plint_out_if.sv
rtl/plint_ram.sv
rtl/plint_front.sv
rtl/plint_back.sv
rtl/piecewise_linear_interpolator.sv
bench/plint_scoreboard.sv
bench/piecewise_linear_interpolator_tb.sv
